// ----- rtl/mcps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcps_pkg
// Shared widths, codes, controller/datapath bundles and fixed-point helpers.
// ----------------------------------------------------------------------------
package mcps_pkg;

  localparam int MAX_STATES  = 16;
  localparam int IDX_W       = $clog2(MAX_STATES);
  localparam int CNT_W       = $clog2(MAX_STATES + 1);
  localparam int MTX_DEPTH   = MAX_STATES * MAX_STATES;
  localparam int MTX_AW      = 2 * IDX_W;
  localparam int OP_W        = 2;
  localparam int DATA_W      = 32;
  localparam int STEP_W      = 16;
  localparam int CFG_W       = 5;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int Q_FRAC      = 30;
  localparam int RND_W       = PROD_W - Q_FRAC;
  localparam int ACC_W       = RND_W + IDX_W + 2;

  localparam logic [CFG_W-1:0] STATE_COUNT_RST = CFG_W'(1);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (Q_FRAC - 1));
  localparam logic signed [ACC_W-1:0]  ACC_HI     = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0]  ACC_LO     = ~ACC_HI;

  typedef enum logic [OP_W-1:0] {
    OP_MTX   = 2'd0,
    OP_START = 2'd1,
    OP_RUN   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             mtx_wr;
    logic             start_wr;
    logic             init_copy;
    logic             mac_issue;
    logic [IDX_W-1:0] mac_row;
    logic [IDX_W-1:0] mac_col;
    logic             mac_first;
    logic             mac_last;
    logic             step_copy;
    logic             out_load;
    logic [IDX_W-1:0] out_idx;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } status_t;

  // zero means one state, anything above storage is clipped
  function automatic logic [CNT_W-1:0] active_states(input logic [CFG_W-1:0] sc);
    logic [CNT_W-1:0] n;
    n = CNT_W'(sc);
    if (sc == '0) begin
      n = CNT_W'(1);
    end else if (32'(sc) > MAX_STATES) begin
      n = CNT_W'(MAX_STATES);
    end
    return n;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    r = DATA_W'(v);
    if (v > ACC_HI) begin
      r = DATA_W'(ACC_HI);
    end else if (v < ACC_LO) begin
      r = DATA_W'(ACC_LO);
    end
    return r;
  endfunction

endpackage

// ----- rtl/mcps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcps_if
// Valid/ready channel interfaces for load/run words, results and config.
// ----------------------------------------------------------------------------
interface mcps_in_if import mcps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] entry_value;
  logic [STEP_W-1:0]        step_count;

  modport source (output valid, opcode, row_index, col_index, entry_value, step_count,
                  input ready);
  modport sink   (input valid, opcode, row_index, col_index, entry_value, step_count,
                  output ready);
endinterface

interface mcps_out_if import mcps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         state_index;
  logic signed [DATA_W-1:0] probability;
  logic                     last_result;

  modport source (output valid, state_index, probability, last_result, input ready);
  modport sink   (input valid, state_index, probability, last_result, output ready);
endinterface

interface mcps_cfg_if import mcps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/mcps_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcps_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module mcps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mcps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcps_ctrl
// Sequencer: decodes words, walks rows/columns/steps, drives result emission.
// ----------------------------------------------------------------------------
module mcps_ctrl import mcps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [STEP_W-1:0] in_step_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  input  status_t           status,
  output cmd_t              cmd
);

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  state_count_r;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [IDX_W-1:0]  n_m1;

  assign cfg_ready = 1'b1;
  assign n_m1      = IDX_W'(n_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      state_count_r <= STATE_COUNT_RST;
      n_r           <= CNT_W'(1);
      steps_r       <= '0;
      row_r         <= '0;
      col_r         <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      steps_r <= steps_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      if (cfg_valid) begin
        state_count_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    steps_nxt = steps_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_MTX:   cmd.mtx_wr   = 1'b1;
            OP_START: cmd.start_wr = 1'b1;
            OP_RUN: begin
              n_nxt     = active_states(state_count_r);
              steps_nxt = in_step_count;
              state_nxt = ST_INIT;
            end
            default: ;
          endcase
        end
      end

      ST_INIT: begin
        cmd.init_copy = 1'b1;
        row_nxt       = '0;
        col_nxt       = '0;
        state_nxt     = (steps_r == '0) ? ST_EMIT : ST_MAC;
      end

      // inner index is the row: one column's dot product finishes per sweep
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_row   = row_r;
        cmd.mac_col   = col_r;
        cmd.mac_first = (row_r == '0);
        cmd.mac_last  = (row_r == n_m1);
        if (row_r == n_m1) begin
          row_nxt = '0;
          if (col_r == n_m1) begin
            col_nxt   = '0;
            state_nxt = ST_DRAIN;
          end else begin
            col_nxt = col_r + IDX_W'(1);
          end
        end else begin
          row_nxt = row_r + IDX_W'(1);
        end
      end

      ST_DRAIN: begin
        if (status.pipe_empty) begin
          cmd.step_copy = 1'b1;
          if (steps_r == STEP_W'(1)) begin
            state_nxt = ST_EMIT;
          end else begin
            steps_nxt = steps_r - STEP_W'(1);
            state_nxt = ST_MAC;
          end
        end
      end

      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_idx  = row_r;
          cmd.out_last = (row_r == n_m1);
          if (row_r == n_m1) begin
            row_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_r + IDX_W'(1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded into a full output register");

  a_copy_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_copy |-> status.pipe_empty)
    else $error("vector copied with products still in flight");

  a_pipe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    !status.pipe_empty |-> (state_r == ST_MAC || state_r == ST_DRAIN))
    else $error("MAC pipeline busy outside a step");

endmodule

// ----- rtl/mcps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcps_dp
// Datapath: matrix RAM, vectors, MAC pipeline and output register.
// ----------------------------------------------------------------------------
module mcps_dp import mcps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic [IDX_W-1:0]         in_row,
  input  logic [IDX_W-1:0]         in_col,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_idx,
  output logic signed [DATA_W-1:0] out_prob,
  output logic                     out_last
);

  logic [MTX_DEPTH-1:0]     mvalid_r;
  logic [MTX_AW-1:0]        waddr, raddr;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] mtx_op;

  logic signed [DATA_W-1:0] start_r [MAX_STATES];
  logic signed [DATA_W-1:0] work_r  [MAX_STATES];
  logic signed [DATA_W-1:0] next_r  [MAX_STATES];
  logic [IDX_W-1:0]         vec_idx;
  logic signed [DATA_W-1:0] vec_rd;

  logic                     s1_v_r, s2_v_r, s3_v_r;
  logic                     s1_first_r, s2_first_r, s3_first_r;
  logic                     s1_last_r, s2_last_r, s3_last_r;
  logic [IDX_W-1:0]         s1_col_r, s2_col_r, s3_col_r;
  logic signed [DATA_W-1:0] a_r;
  logic                     vbit_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] biased;
  logic signed [RND_W-1:0]  rnd_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [DATA_W-1:0] out_prob_r;
  logic                     out_last_r;

  assign waddr = {in_row, in_col};
  assign raddr = {cmd.mac_row, cmd.mac_col};

  mcps_ram #(.WIDTH(DATA_W), .DEPTH(MTX_DEPTH)) u_mtx (
    .clk   (clk),
    .we    (cmd.mtx_wr),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvalid_r <= '0;
    end else if (cmd.mtx_wr) begin
      mvalid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_STATES; k++) begin
        start_r[k] <= '0;
      end
    end else if (cmd.start_wr) begin
      start_r[in_row] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_STATES; k++) begin
      if (cmd.init_copy) begin
        work_r[k] <= start_r[k];
      end else if (cmd.step_copy) begin
        work_r[k] <= next_r[k];
      end
    end
    if (s3_v_r && s3_last_r) begin
      next_r[s3_col_r] <= sat32(acc_nxt);
    end
  end

  // single read port on the working vector, shared by MAC and emission
  assign vec_idx = cmd.out_load ? cmd.out_idx : cmd.mac_row;
  assign vec_rd  = work_r[vec_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.mac_issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign mtx_op = vbit_r ? $signed(rdata) : '0;
  assign biased = prod_r + ROUND_HALF;
  assign acc_nxt = s3_first_r ? ACC_W'(rnd_r) : acc_r + ACC_W'(rnd_r);

  always_ff @(posedge clk) begin
    // stage 1: operand fetch
    a_r        <= vec_rd;
    vbit_r     <= mvalid_r[raddr];
    s1_first_r <= cmd.mac_first;
    s1_last_r  <= cmd.mac_last;
    s1_col_r   <= cmd.mac_col;
    // stage 2: full-precision product
    prod_r     <= a_r * mtx_op;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_col_r   <= s1_col_r;
    // stage 3: round to nearest, ties up
    rnd_r      <= RND_W'(biased >>> Q_FRAC);
    s3_first_r <= s2_first_r;
    s3_last_r  <= s2_last_r;
    s3_col_r   <= s2_col_r;
    if (s3_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign status.pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;
  assign status.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r  <= cmd.out_idx;
      out_prob_r <= vec_rd;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_prob  = out_prob_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/markov_chain_power_step_core.sv -----
`timescale 1ns / 1ps
// A load word (matrix or start entry) is taken while the core is idle, one word per cycle.
// Run word: the start vector is copied in, then each step issues one MAC per cycle
//   per row/column pair into a 3-stage fetch/multiply/round pipe feeding the accumulator,
//   then drains and copies the vector; then n result words, one per cycle if taken.
// Throughput is set by the single shared MAC unit and matrix RAM read port.
// Reset (rst_n, synchronous): matrix and start vector read as zero, state_count = 1.
// ----------------------------------------------------------------------------
// markov_chain_power_step_core
// Markov chain v_n = v_0 * P^n engine, signed Q2.30, saturating accumulate.
// ----------------------------------------------------------------------------
module markov_chain_power_step_core import mcps_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  mcps_in_if.sink        in_if,
  mcps_out_if.source     out_if,
  mcps_cfg_if.sink       cfg_if
);

  cmd_t    cmd;
  status_t status;

  // Controller: accepts words only when idle; a run holds the block until
  // the final result word has been loaded into the output register.
  mcps_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_opcode     (in_if.opcode),
    .in_step_count (in_if.step_count),
    .cfg_valid     (cfg_if.valid),
    .cfg_ready     (cfg_if.ready),
    .cfg_data      (cfg_if.data),
    .status        (status),
    .cmd           (cmd)
  );

  // Datapath: matrix lives in RAM with per-entry valid flags so that reset
  // needs no clearing sweep; the output register lets new load words in
  // while the final result still waits downstream.
  mcps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_row    (in_if.row_index),
    .in_col    (in_if.col_index),
    .in_value  (in_if.entry_value),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_idx   (out_if.state_index),
    .out_prob  (out_if.probability),
    .out_last  (out_if.last_result)
  );

endmodule
